### design/rc5_pkg.sv
// Package: shared types and constants for the RC5 infrared decoder.
`default_nettype none

package rc5_pkg;

  // Register indexes on the configuration channel
  localparam int unsigned CfgIdxWidth = 3;
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SHORT_LIM  = 3'd0,
    CFG_PULSE_HALF = 3'd1,
    CFG_END_LIM    = 3'd2,
    CFG_QUIET_LIM  = 3'd3
  } cfg_idx_e;

  // Field widths
  localparam int unsigned TimerWidth = 8;
  localparam int unsigned QuietWidth = 16;
  localparam int unsigned CodeWidth  = 14;
  localparam int unsigned ShiftWidth = CodeWidth + 1;
  localparam int unsigned TallyWidth = 6;

  // Frame markers inside the shift word
  localparam int unsigned StartBit    = CodeWidth - 1;   // first start bit lands here
  localparam int unsigned OverflowBit = CodeWidth;       // word holds too many bits

  // Repeat count saturation
  localparam logic [TallyWidth-1:0] TallyMax = TallyWidth'(50);

  // Register reset values
  localparam logic [TimerWidth-1:0] ShortLimReset  = TimerWidth'(5);
  localparam logic [TimerWidth-1:0] PulseHalfReset = TimerWidth'(10);
  localparam logic [TimerWidth-1:0] EndLimReset    = TimerWidth'(15);
  localparam logic [QuietWidth-1:0] QuietLimReset  = QuietWidth'(768);

  // Configuration write item
  typedef struct packed {
    cfg_idx_e                index;
    logic [QuietWidth-1:0]   value;
  } cfg_wr_t;

  // Timing thresholds as seen by the decoder
  typedef struct packed {
    logic [TimerWidth-1:0] short_lim;
    logic [TimerWidth-1:0] pulse_half;
    logic [TimerWidth-1:0] end_lim;
    logic [QuietWidth-1:0] quiet_lim;
  } rc5_cfg_t;

  // Input item: one pin sample
  typedef struct packed {
    logic ir_level;
  } ir_item_t;

  // Result item
  typedef struct packed {
    logic                  code_valid;
    logic [CodeWidth-1:0]  code_word;
    logic [TallyWidth-1:0] repeat_count;
    logic                  pause_seen;
    logic                  led_level;
  } rc5_result_t;

endpackage

`default_nettype wire

### design/rc5_chan_if.sv
// Interface: valid/ready channel carrying one payload item.
`default_nettype none

interface rc5_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/rc5_ir_decoder_top.sv
// Top level: RC5 infrared decoder with input register and result register.
`default_nettype none

// RC5 infrared decoder. Each item on ir_i is one sample of the low-active
// receiver pin; every sample yields exactly one result item on res_o with the
// capture flag, the last captured 14-bit word, the repeat count and the pause
// flag. The block takes one sample per clock unless res_o stalls: a sample
// sits in the input register, runs through the decode logic as it moves to
// the result register, and a new sample is accepted in the same cycle. A
// result is offered on res_o once its sample reaches the result register;
// while a result waits, one more sample can be held in the input register
// before ir_i stalls. Timing thresholds are written through cfg_i, which is
// always ready; write them only while no sample is in flight.
module rc5_ir_decoder_top
  import rc5_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rc5_chan_if.sink   cfg_i,
  rc5_chan_if.sink   ir_i,
  rc5_chan_if.source res_o
);

  rc5_cfg_t    cfg;
  rc5_result_t step_res;
  logic        in_valid_q, in_level_q;
  logic        out_valid_q;
  rc5_result_t out_data_q;
  logic        advance;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  rc5_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .wr_i    (cfg_i.data),
    .cfg_o   (cfg)
  );

  // Sample moves on when the result register is free or drains this cycle
  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign ir_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (ir_i.ready) begin
      in_valid_q <= ir_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ir_i.valid && ir_i.ready) begin
      in_level_q <= ir_i.data.ir_level;
    end
  end

  // Decode logic and state
  rc5_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .level_i  (in_level_q),
    .result_o (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= step_res;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

endmodule

`default_nettype wire

### design/rc5_cfg.sv
// Configuration register file for the decoder timing thresholds.
`default_nettype none

module rc5_cfg
  import rc5_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_en_i,
  input  wire cfg_wr_t  wr_i,
  output rc5_cfg_t      cfg_o
);

  rc5_cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_i.index)
        CFG_SHORT_LIM:  cfg_d.short_lim  = wr_i.value[TimerWidth-1:0];
        CFG_PULSE_HALF: cfg_d.pulse_half = wr_i.value[TimerWidth-1:0];
        CFG_END_LIM:    cfg_d.end_lim    = wr_i.value[TimerWidth-1:0];
        CFG_QUIET_LIM:  cfg_d.quiet_lim  = wr_i.value;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_lim  <= ShortLimReset;
      cfg_q.pulse_half <= PulseHalfReset;
      cfg_q.end_lim    <= EndLimReset;
      cfg_q.quiet_lim  <= QuietLimReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### design/rc5_core.sv
// Decoder core: edge timing state and the per-sample update logic.
`default_nettype none

module rc5_core
  import rc5_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire rc5_cfg_t cfg_i,
  input  wire logic     step_i,    // consume one sample this cycle
  input  wire logic     level_i,
  output rc5_result_t   result_o
);

  logic                  last_q, last_d;
  logic [TimerWidth-1:0] timer_q, timer_d;
  logic [ShiftWidth-1:0] shift_q, shift_d;
  logic [CodeWidth-1:0]  held_q, held_d;
  logic [TallyWidth-1:0] tally_q, tally_d;
  logic [QuietWidth-1:0] quiet_q, quiet_d;

  logic [TimerWidth-1:0] timer_inc;
  logic                  frame_end, capture, edge_seen, take_bit, pause;
  logic [ShiftWidth-1:0] word_a, word_b, word_sh;
  logic [QuietWidth-1:0] quiet_a, quiet_inc;

  // Frame end and capture of a complete 14-bit word
  assign timer_inc = timer_q + TimerWidth'(1);
  assign frame_end = timer_inc > cfg_i.end_lim;
  assign capture   = frame_end && !shift_q[OverflowBit] && shift_q[StartBit];
  assign word_a    = frame_end ? '0 : shift_q;

  always_comb begin
    held_d  = held_q;
    tally_d = tally_q;
    if (capture) begin
      if (shift_q[CodeWidth-1:0] == held_q) begin
        tally_d = (tally_q < TallyMax) ? tally_q + TallyWidth'(1) : TallyMax;
      end else begin
        held_d  = shift_q[CodeWidth-1:0];
        tally_d = '0;
      end
    end
  end

  // Edge handling: drop short pulses, sample on start or long pulse
  assign edge_seen = level_i != last_q;
  assign word_b    = (edge_seen && (timer_inc < cfg_i.short_lim)) ? '0 : word_a;
  assign take_bit  = edge_seen && ((word_b == '0) || (timer_inc > cfg_i.pulse_half));
  // full word keeps its bits in place, new bit is OR-ed into bit 0
  assign word_sh   = word_b[OverflowBit] ? word_b : {word_b[ShiftWidth-2:0], 1'b0};

  always_comb begin
    shift_d = word_b;
    timer_d = timer_inc;
    if (take_bit) begin
      shift_d = {word_sh[ShiftWidth-1:1], word_sh[0] | ~level_i};
      timer_d = '0;
    end
  end

  // Quiet tick counter and pause flag
  assign quiet_a   = (capture || edge_seen) ? '0 : quiet_q;
  assign quiet_inc = quiet_a + QuietWidth'(1);
  assign pause     = quiet_inc > cfg_i.quiet_lim;
  assign quiet_d   = pause ? cfg_i.quiet_lim + QuietWidth'(1) : quiet_inc;
  assign last_d    = level_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 1'b0;
      timer_q <= '0;
      shift_q <= '0;
      held_q  <= '0;
      tally_q <= '0;
      quiet_q <= '0;
    end else if (step_i) begin
      last_q  <= last_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      held_q  <= held_d;
      tally_q <= tally_d;
      quiet_q <= quiet_d;
    end
  end

  // Result for this sample
  always_comb begin
    result_o.code_valid   = capture;
    result_o.code_word    = held_d;
    result_o.repeat_count = tally_d;
    result_o.pause_seen   = pause;
    result_o.led_level    = level_i;
  end

endmodule

`default_nettype wire
